>>> design/ttg_pkg.sv
// ----------------------------------------------------------------------------
// ttg_pkg
// Shared types, constants and helpers for the text terminal grid.
// ----------------------------------------------------------------------------
package ttg_pkg;

    localparam int ROWS   = 4;
    localparam int COLS   = 16;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int COL_W  = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int CELLS  = ROWS * COLS;
    localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int CODE_W = 7;
    localparam int FROW_W = 2;
    localparam int FCOL_W = 4;

    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_DEL   = 8'd127;
    localparam logic [CODE_W-1:0] CODE_SPACE = 7'd32;
    localparam logic [CODE_W-1:0] CODE_BLANK = 7'd0;

    localparam logic FUNC_PUT  = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    typedef struct packed {
        logic              func;
        logic [7:0]        char_code;
        logic [FROW_W-1:0] read_row;
        logic [FCOL_W-1:0] read_col;
    } ttg_cmd_t;

    typedef struct packed {
        logic [CODE_W-1:0] read_data;
        logic              cell_written;
        logic [FROW_W-1:0] write_row;
        logic [FCOL_W-1:0] write_col;
        logic [CODE_W-1:0] write_code;
        logic              scrolled;
        logic [FROW_W-1:0] cursor_row;
        logic [FCOL_W-1:0] cursor_col;
    } ttg_rsp_t;

    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic              scroll;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [CODE_W-1:0] wdata;
    } ttg_mem_ctl_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_RD_WAIT,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_SCROLL,
        S_DONE
    } ttg_state_t;

    function automatic logic [CODE_W-1:0] fold_code(input logic [7:0] ch);
        logic [7:0] c;
        c = ch;
        if (c >= 8'h61 && c <= 8'h7A)
        begin
            c = c - 8'h20;
        end
        if ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A))
        begin
            return c[CODE_W-1:0];
        end
        return CODE_BLANK;
    endfunction

endpackage

>>> design/ttg_grid_store.sv
// ----------------------------------------------------------------------------
// ttg_grid_store
// Cell memory with per-cell valid bits and a rotating top-row base, so a
// scroll is one base step plus clearing the valid bits of one row.
// ----------------------------------------------------------------------------
module ttg_grid_store (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  ttg_pkg::ttg_mem_ctl_t                 ctl,
    output logic [ttg_pkg::CODE_W-1:0]            rdata
);
    import ttg_pkg::*;

    logic [CODE_W-1:0] mem [CELLS];
    logic [CELLS-1:0]  valid_reg;
    logic [ROW_W-1:0]  base_reg;
    logic [CODE_W-1:0] rd_q_reg;
    logic              rd_vld_reg;
    logic [ROW_W:0]    row_sum;
    logic [ROW_W-1:0]  phys_row;
    logic [ADDR_W-1:0] addr;

    function automatic logic [ADDR_W-1:0] addr_of(input logic [ROW_W-1:0] r,
                                                   input logic [COL_W-1:0] c);
        return ADDR_W'(int'(r) * COLS + int'(c));
    endfunction

    always_comb
    begin
        row_sum = {1'b0, ctl.row} + {1'b0, base_reg};
        if (row_sum >= (ROW_W+1)'(ROWS))
        begin
            row_sum = row_sum - (ROW_W+1)'(ROWS);
        end
        phys_row = row_sum[ROW_W-1:0];
        addr     = addr_of(phys_row, ctl.col);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[addr] <= ctl.wdata;
        end
        if (ctl.rd_en)
        begin
            rd_q_reg <= mem[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            base_reg   <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (ctl.rd_en)
            begin
                rd_vld_reg <= valid_reg[addr];
            end
            if (ctl.wr_en)
            begin
                valid_reg[addr] <= 1'b1;
            end
            if (ctl.scroll)
            begin
                for (int c = 0; c < COLS; c++)
                begin
                    valid_reg[addr_of(base_reg, COL_W'(c))] <= 1'b0;
                end
                base_reg <= (base_reg == ROW_W'(ROWS - 1)) ? '0 : base_reg + 1'b1;
            end
        end
    end

    assign rdata = rd_vld_reg ? rd_q_reg : CODE_SPACE;

endmodule

>>> design/text_terminal_grid_unit.sv
// ----------------------------------------------------------------------------
// text_terminal_grid_unit
// Character-cell text grid with cursor: puts received bytes, reads cells.
// ----------------------------------------------------------------------------
//  channel | signals                      | role
//  cmd     | cmd_valid, cmd_ready, cmd    | put character or read cell
//  rsp     | rsp_valid, rsp_ready, rsp    | one result per command
//
//  One command at a time. Read: decode, read wait, done. Put or newline:
//  decode, scroll when the grid scrolls, done. Backspace from column 0 walks
//  the previous row from the right through the single memory read port.
//  Reset clears the grid by valid bits at once, so the block is ready right
//  after reset. A result waiting on rsp_ready does not block the next
//  command until that command's own result is due.
// ----------------------------------------------------------------------------
module text_terminal_grid_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  ttg_pkg::ttg_cmd_t cmd,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output ttg_pkg::ttg_rsp_t rsp
);
    import ttg_pkg::*;

    ttg_state_t        state_reg, state_next;
    ttg_cmd_t          cmd_reg, cmd_next;
    ttg_rsp_t          res_reg, res_next;
    ttg_rsp_t          out_reg, out_next;
    logic              out_valid_reg, out_valid_next;
    logic [ROW_W-1:0]  cur_row_reg, cur_row_next;
    logic [COL_W-1:0]  cur_col_reg, cur_col_next;
    logic [COL_W-1:0]  idx_reg, idx_next;
    ttg_mem_ctl_t      mem_ctl;
    logic [CODE_W-1:0] mem_rdata;
    logic              out_free;
    logic              rd_in_range;
    logic              is_bs;

    ttg_grid_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mem_ctl),
        .rdata (mem_rdata)
    );

    assign out_free    = !out_valid_reg || rsp_ready;
    assign rd_in_range = (int'(cmd_reg.read_row) < ROWS) && (int'(cmd_reg.read_col) < COLS);
    assign is_bs       = (cmd_reg.char_code == CH_BS) || (cmd_reg.char_code == CH_DEL);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (cmd_reg.func == FUNC_READ)
                begin
                    state_next = rd_in_range ? S_RD_WAIT : S_DONE;
                end
                else if (cmd_reg.char_code == CH_CR)
                begin
                    state_next = S_DONE;
                end
                else if (cmd_reg.char_code == CH_LF)
                begin
                    state_next = (cur_row_reg == ROW_W'(ROWS - 1)) ? S_SCROLL : S_DONE;
                end
                else if (is_bs)
                begin
                    state_next = (cur_col_reg == '0 && cur_row_reg != '0) ? S_SRCH_RD : S_DONE;
                end
                else if (cur_col_reg == COL_W'(COLS - 1) && cur_row_reg == ROW_W'(ROWS - 1))
                begin
                    state_next = S_SCROLL;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_RD_WAIT:  state_next = S_DONE;
            S_SRCH_RD:  state_next = S_SRCH_CMP;
            S_SRCH_CMP:
            begin
                if (mem_rdata != CODE_SPACE || idx_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_SRCH_RD;
                end
            end
            S_SCROLL:   state_next = S_DONE;
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        cmd_next       = cmd_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        idx_next       = idx_reg;
        cmd_ready      = 1'b0;
        mem_ctl        = '0;

        if (out_valid_reg && rsp_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    cmd_next = cmd;
                    res_next = '0;
                end
            end
            S_DECODE:
            begin
                if (cmd_reg.func == FUNC_READ)
                begin
                    mem_ctl.rd_en = rd_in_range;
                    mem_ctl.row   = ROW_W'(cmd_reg.read_row);
                    mem_ctl.col   = COL_W'(cmd_reg.read_col);
                end
                else if (cmd_reg.char_code == CH_CR)
                begin
                end
                else if (cmd_reg.char_code == CH_LF)
                begin
                    cur_col_next = '0;
                    if (cur_row_reg != ROW_W'(ROWS - 1))
                    begin
                        cur_row_next = cur_row_reg + 1'b1;
                    end
                end
                else if (is_bs)
                begin
                    if (cur_col_reg != '0)
                    begin
                        cur_col_next          = cur_col_reg - 1'b1;
                        mem_ctl.wr_en         = 1'b1;
                        mem_ctl.row           = cur_row_reg;
                        mem_ctl.col           = cur_col_reg - 1'b1;
                        mem_ctl.wdata         = CODE_SPACE;
                        res_next.cell_written = 1'b1;
                        res_next.write_row    = FROW_W'(cur_row_reg);
                        res_next.write_col    = FCOL_W'(cur_col_reg - 1'b1);
                        res_next.write_code   = CODE_SPACE;
                    end
                    else if (cur_row_reg != '0)
                    begin
                        cur_row_next = cur_row_reg - 1'b1;
                        idx_next     = COL_W'(COLS - 1);
                    end
                end
                else
                begin
                    mem_ctl.wr_en         = 1'b1;
                    mem_ctl.row           = cur_row_reg;
                    mem_ctl.col           = cur_col_reg;
                    mem_ctl.wdata         = fold_code(cmd_reg.char_code);
                    res_next.cell_written = 1'b1;
                    res_next.write_row    = FROW_W'(cur_row_reg);
                    res_next.write_col    = FCOL_W'(cur_col_reg);
                    res_next.write_code   = fold_code(cmd_reg.char_code);
                    if (cur_col_reg == COL_W'(COLS - 1))
                    begin
                        cur_col_next = '0;
                        if (cur_row_reg != ROW_W'(ROWS - 1))
                        begin
                            cur_row_next = cur_row_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        cur_col_next = cur_col_reg + 1'b1;
                    end
                end
            end
            S_RD_WAIT:
            begin
                res_next.read_data = mem_rdata;
            end
            S_SRCH_RD:
            begin
                mem_ctl.rd_en = 1'b1;
                mem_ctl.row   = cur_row_reg;
                mem_ctl.col   = idx_reg;
            end
            S_SRCH_CMP:
            begin
                if (mem_rdata != CODE_SPACE)
                begin
                    cur_col_next          = idx_reg;
                    mem_ctl.wr_en         = 1'b1;
                    mem_ctl.row           = cur_row_reg;
                    mem_ctl.col           = idx_reg;
                    mem_ctl.wdata         = CODE_SPACE;
                    res_next.cell_written = 1'b1;
                    res_next.write_row    = FROW_W'(cur_row_reg);
                    res_next.write_col    = FCOL_W'(idx_reg);
                    res_next.write_code   = CODE_SPACE;
                end
                else if (idx_reg == '0)
                begin
                    cur_col_next = '0;
                end
                else
                begin
                    idx_next = idx_reg - 1'b1;
                end
            end
            S_SCROLL:
            begin
                mem_ctl.scroll     = 1'b1;
                cur_row_next       = ROW_W'(ROWS - 1);
                cur_col_next       = '0;
                res_next.scrolled  = 1'b1;
                if (res_reg.write_row != '0)
                begin
                    res_next.write_row = res_reg.write_row - 1'b1;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_next            = res_reg;
                    out_next.cursor_row = FROW_W'(cur_row_reg);
                    out_next.cursor_col = FCOL_W'(cur_col_reg);
                    out_valid_next      = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        res_reg <= res_next;
        out_reg <= out_next;
        idx_reg <= idx_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule
